// ----- src/ctsr_pkg.sv -----
// Shared types and constants for the cyclic tour segment reversal core.
// Used by the top level; no dependencies of its own.
`default_nettype none

package ctsr_pkg;

  localparam int CITY_W     = 8;
  localparam int POS_W      = 8;
  localparam int CFG_W      = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [CFG_W-1:0] NUM_CITIES_RESET = 9'd256;

  localparam logic REG_NUM_CITIES = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REVERSE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SCAN,
    ST_PLAN,
    ST_SWAP,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ----- src/ctsr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module ctsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/cyclic_tour_segment_reversal_core.sv -----
// Load, no-op and out-of-range commands go straight to the response state, a read waits for the
// registered RAM data, and a reverse scans the tour at one entry per cycle and then, if both
// cities are found, swaps floor(len / 2) pairs through one write port, with len the segment length.
// One command is in flight at a time, so a new beat is taken only once the last result has
// left the response state, and a finished result waits in the output register.
// Reset clears the control state and sets num_cities to 256; the tour RAM is not cleared.
`default_nettype none

module cyclic_tour_segment_reversal_core
  import ctsr_pkg::*;
#(
  parameter int MAX_CITIES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // position[7:0], city[15:8], other_city[23:16]
  input  wire logic [1:0]            in_tuser,   // command[1:0]
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // read_city[7:0]
  output logic [1:0]                 out_tuser,  // status[1:0]
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int AW = $clog2(MAX_CITIES);
  localparam int XW = (AW + 1 > CFG_W + 1) ? AW + 1 : CFG_W + 1;

  state_t              state_r, state_nxt;
  logic [CITY_W-1:0]   g_r, g_nxt;
  logic [CITY_W-1:0]   gl_r, gl_nxt;
  logic [XW-1:0]       idx_r, idx_nxt;
  logic [XW-1:0]       p1_r, p1_nxt;
  logic [XW-1:0]       p2_r, p2_nxt;
  logic                fg_r, fg_nxt;
  logic                fgl_r, fgl_nxt;
  logic [XW-1:0]       swaps_r, swaps_nxt;
  logic                ph_r, ph_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       wa_r, wa_nxt;
  logic [AW-1:0]       wb_r, wb_nxt;
  logic [CITY_W-1:0]   d1_r, d1_nxt;
  logic [CITY_W-1:0]   res_city_r, res_city_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CITY_W-1:0]   out_city_r, out_city_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [CFG_W-1:0]    num_cities_r;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [CITY_W-1:0]   ram_wdata, ram_rdata;

  logic [XW-1:0]       n_w;
  logic [POS_W-1:0]    in_pos;
  logic [CITY_W-1:0]   in_city, in_other;
  cmd_t                in_cmd;
  logic                pos_ok;
  logic                cfg_write;
  logic [XW-1:0]       seg_len;
  logic [XW-1:0]       p1_step, p2_step;

  assign in_pos   = in_tdata[7:0];
  assign in_city  = in_tdata[15:8];
  assign in_other = in_tdata[23:16];
  assign in_cmd   = cmd_t'(in_tuser);

  assign n_w = (32'(num_cities_r) > 32'(MAX_CITIES)) ? XW'(MAX_CITIES) : XW'(num_cities_r);
  assign pos_ok  = XW'(in_pos) < n_w;
  assign seg_len = (p2_r > p1_r) ? (p2_r - p1_r + XW'(1)) : (n_w - p1_r + p2_r + XW'(1));
  assign p1_step = (p1_r + XW'(1) == n_w) ? '0 : p1_r + XW'(1);
  assign p2_step = (p2_r == '0) ? n_w - XW'(1) : p2_r - XW'(1);

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_NUM_CITIES) begin
      cfg_prdata = APB_DATA_W'(num_cities_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cities_r <= NUM_CITIES_RESET;
    end else if (cfg_write && cfg_paddr[2] == REG_NUM_CITIES) begin
      num_cities_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  ctsr_ram #(
    .WIDTH(CITY_W),
    .DEPTH(MAX_CITIES)
  ) u_tour_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      fg_r        <= 1'b0;
      fgl_r       <= 1'b0;
      ph_r        <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fg_r        <= fg_nxt;
      fgl_r       <= fgl_nxt;
      ph_r        <= ph_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r          <= g_nxt;
    gl_r         <= gl_nxt;
    idx_r        <= idx_nxt;
    p1_r         <= p1_nxt;
    p2_r         <= p2_nxt;
    swaps_r      <= swaps_nxt;
    wa_r         <= wa_nxt;
    wb_r         <= wb_nxt;
    d1_r         <= d1_nxt;
    res_city_r   <= res_city_nxt;
    res_status_r <= res_status_nxt;
    out_city_r   <= out_city_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    g_nxt          = g_r;
    gl_nxt         = gl_r;
    idx_nxt        = idx_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    fg_nxt         = fg_r;
    fgl_nxt        = fgl_r;
    swaps_nxt      = swaps_r;
    ph_nxt         = ph_r;
    pend_nxt       = pend_r;
    wa_nxt         = wa_r;
    wb_nxt         = wb_r;
    d1_nxt         = d1_r;
    res_city_nxt   = res_city_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_city_nxt   = out_city_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    in_tready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          g_nxt          = in_city;
          gl_nxt         = in_other;
          res_city_nxt   = '0;
          res_status_nxt = STAT_OK;
          state_nxt      = ST_RESP;
          unique case (in_cmd)
            CMD_LOAD: begin
              if (pos_ok) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(in_pos);
                ram_wdata = in_city;
              end else begin
                res_status_nxt = STAT_RANGE;
              end
            end
            CMD_READ: begin
              if (pos_ok) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_pos);
                state_nxt = ST_RDWAIT;
              end else begin
                res_status_nxt = STAT_RANGE;
              end
            end
            CMD_REVERSE: begin
              fg_nxt  = 1'b0;
              fgl_nxt = 1'b0;
              idx_nxt = '0;
              if (n_w == '0) begin
                res_status_nxt = STAT_NOT_FOUND;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_NOP: begin
              res_status_nxt = STAT_OK;
            end
            default: begin
              res_status_nxt = STAT_OK;
            end
          endcase
        end
      end

      ST_RDWAIT: begin
        res_city_nxt = ram_rdata;
        state_nxt    = ST_RESP;
      end

      ST_SCAN: begin
        if (idx_r != n_w) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
        end
        if (idx_r != '0) begin
          if (ram_rdata == g_r) begin
            fg_nxt = 1'b1;
            p1_nxt = (idx_r == n_w) ? '0 : idx_r;
          end
          if (ram_rdata == gl_r) begin
            fgl_nxt = 1'b1;
            p2_nxt  = idx_r - XW'(1);
          end
        end
        if (idx_r == n_w) begin
          state_nxt = ST_PLAN;
        end else begin
          idx_nxt = idx_r + XW'(1);
        end
      end

      ST_PLAN: begin
        if (!(fg_r && fgl_r)) begin
          res_status_nxt = STAT_NOT_FOUND;
          state_nxt      = ST_RESP;
        end else if (p1_r == p2_r) begin
          state_nxt = ST_RESP;
        end else begin
          swaps_nxt = seg_len >> 1;
          ph_nxt    = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SWAP;
        end
      end

      ST_SWAP: begin
        if (!ph_r) begin
          // Second read of the previous pair lands now; it goes to the first position.
          if (pend_r) begin
            ram_we    = 1'b1;
            ram_waddr = wa_r;
            ram_wdata = ram_rdata;
          end
          if (swaps_r != '0) begin
            ram_re    = 1'b1;
            ram_raddr = p1_r[AW-1:0];
          end
          ph_nxt = 1'b1;
        end else begin
          if (pend_r) begin
            ram_we    = 1'b1;
            ram_waddr = wb_r;
            ram_wdata = d1_r;
          end
          ph_nxt = 1'b0;
          if (swaps_r != '0) begin
            d1_nxt    = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = p2_r[AW-1:0];
            wa_nxt    = p1_r[AW-1:0];
            wb_nxt    = p2_r[AW-1:0];
            p1_nxt    = p1_step;
            p2_nxt    = p2_step;
            swaps_nxt = swaps_r - XW'(1);
            pend_nxt  = 1'b1;
          end else begin
            pend_nxt  = 1'b0;
            state_nxt = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_city_nxt   = res_city_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_city_r;
  assign out_tuser  = out_status_r;

  // The search scan only reads the tour.
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("tour RAM written during search scan");

  // A swap never reads the entry it writes in the same cycle.
  a_swap_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWAP && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("swap read and write hit the same entry");

  // Swap pointers stay inside the active tour.
  a_swap_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWAP && swaps_r != '0) |-> (p1_r < n_w && p2_r < n_w))
    else $error("swap pointer outside active tour");

  // A pending result is not dropped while the output register is still full.
  a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_valid_r && !out_tready) |=> (state_r == ST_RESP))
    else $error("result left response state while output was stalled");

endmodule

`default_nettype wire
